// ----- design/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_pkg: shared types and codes of the periodic event scheduler
// function and status codes, controller-to-datapath command struct
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int unsigned FuncBits   = 2;
  localparam int unsigned StatusBits = 2;

  localparam logic [FuncBits-1:0] FUNC_REGISTER = 2'd0;
  localparam logic [FuncBits-1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [FuncBits-1:0] FUNC_CLEAR    = 2'd2;

  localparam logic [StatusBits-1:0] ST_OK    = 2'd0;
  localparam logic [StatusBits-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusBits-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusBits-1:0] ST_SAT   = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input transaction
    logic reg_write; // write new entry at slot entry_count
    logic clear;     // empty the table
    logic scan_start;// issue read of slot 0
    logic scan_step; // compare read data, issue next read
    logic fire;      // capture best entry as result, write back advanced due time
  } pes_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last; // the read in flight is the last valid slot
  } pes_stat_t;

endpackage

// ----- design/pes_datapath.sv -----
// ----------------------------------------------------------------------------
// pes_datapath: entry memory, linear minimum search and result register
// one memory read per cycle during the scan, one write on register or fire
// ----------------------------------------------------------------------------
module pes_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 32,
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pes_pkg::pes_cmd_t             cmd_i,
  output pes_pkg::pes_stat_t            stat_o,
  input  logic [ID_BITS-1:0]            entry_id_i,
  input  logic [PERIOD_BITS-1:0]        period_i,
  input  logic [pes_pkg::FuncBits-1:0]  func_i,
  output logic [pes_pkg::StatusBits-1:0] status_o,
  output logic [ID_BITS-1:0]            dispatched_id_o,
  output logic [TIME_BITS-1:0]          dispatch_time_o
);
  import pes_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = ID_BITS + PERIOD_BITS + TIME_BITS;
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};
  // period fits in time when narrower; otherwise it may saturate
  localparam int unsigned SW = (PERIOD_BITS > TIME_BITS) ? PERIOD_BITS : TIME_BITS;

  logic [EW-1:0] mem_q [QUEUE_DEPTH];
  logic [EW-1:0] rd_q;

  logic [CW-1:0] count_q;
  logic [ID_BITS-1:0]     id_q;
  logic [PERIOD_BITS-1:0] per_q;
  logic [FuncBits-1:0]    func_q;
  logic [CW-1:0] rd_idx_q;   // index of slot whose data arrives in rd_q
  logic [CW-1:0] next_idx_q; // next slot to read
  logic          have_best_q;
  logic [AW-1:0] best_idx_q;
  logic [ID_BITS-1:0]     best_id_q;
  logic [PERIOD_BITS-1:0] best_per_q;
  logic [TIME_BITS-1:0]   best_due_q;

  logic [ID_BITS-1:0]     rd_id;
  logic [PERIOD_BITS-1:0] rd_per;
  logic [TIME_BITS-1:0]   rd_due;
  logic                   take;
  logic [TIME_BITS:0]     adv_sum;
  logic [SW:0]            per_ext;
  logic                   adv_sat;
  logic                   reg_sat;
  logic [TIME_BITS-1:0]   adv_due;
  logic [TIME_BITS-1:0]   reg_due;

  assign rd_id  = rd_q[EW-1 -: ID_BITS];
  assign rd_per = rd_q[TIME_BITS +: PERIOD_BITS];
  assign rd_due = rd_q[TIME_BITS-1:0];

  // comparison of the just-read slot against the best so far
  assign take = !have_best_q || (rd_due < best_due_q) ||
                ((rd_due == best_due_q) && (rd_id < best_id_q));

  // due time advance with saturation
  assign per_ext = (SW+1)'(best_per_q);
  assign adv_sat = (per_ext > (SW+1)'(TimeMax)) ||
                   ((SW+1)'(best_per_q) + (SW+1)'(best_due_q) > (SW+1)'(TimeMax));
  assign adv_sum = (TIME_BITS+1)'(best_due_q) + (TIME_BITS+1)'(best_per_q);
  assign adv_due = adv_sat ? TimeMax : adv_sum[TIME_BITS-1:0];

  // first due time equals the period, saturated
  assign reg_sat = (SW+1)'(per_q) > (SW+1)'(TimeMax);
  assign reg_due = reg_sat ? TimeMax : TIME_BITS'(per_q);

  assign stat_o.full      = (count_q >= CW'(QUEUE_DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.scan_last = (rd_idx_q + CW'(1) == count_q);

  // entry memory, single write and single registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_write) begin
      mem_q[count_q[AW-1:0]] <= {id_q, per_q, reg_due};
    end else if (cmd_i.fire) begin
      mem_q[best_idx_q] <= {best_id_q, best_per_q, adv_due};
    end
    if (cmd_i.scan_start) begin
      rd_q <= mem_q[AW'(0)];
    end else if (cmd_i.scan_step) begin
      rd_q <= mem_q[next_idx_q[AW-1:0]];
    end
  end

  // control registers: count, scan indices, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      status_o        <= ST_OK;
      dispatched_id_o <= '0;
      dispatch_time_o <= '0;
      have_best_q     <= 1'b0;
      rd_idx_q        <= '0;
      next_idx_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        status_o        <= ST_OK;
        dispatched_id_o <= '0;
        dispatch_time_o <= '0;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.reg_write) begin
        count_q <= count_q + CW'(1);
        if (reg_sat) status_o <= ST_SAT;
      end
      // status for register on full table or dispatch on empty
      if (cmd_i.load) begin
        // set below once func is known
      end else if (func_q == FUNC_REGISTER && stat_o.full && cmd_i.clear == 1'b0
                   && cmd_i.scan_start) begin
        status_o <= ST_FULL;
      end
      if (cmd_i.scan_start) begin
        have_best_q <= 1'b0;
        rd_idx_q    <= '0;
        next_idx_q  <= CW'(1);
        if (func_q == FUNC_DISPATCH && stat_o.empty) status_o <= ST_EMPTY;
      end
      if (cmd_i.scan_step) begin
        have_best_q <= 1'b1;
        rd_idx_q    <= next_idx_q;
        next_idx_q  <= next_idx_q + CW'(1);
      end
      if (cmd_i.fire) begin
        dispatched_id_o <= best_id_q;
        dispatch_time_o <= best_due_q;
        if (adv_sat) status_o <= ST_SAT;
      end
    end
  end

  // payload captures
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q   <= entry_id_i;
      per_q  <= period_i;
      func_q <= func_i;
    end
    if (cmd_i.scan_step && take) begin
      best_idx_q <= rd_idx_q[AW-1:0];
      best_id_q  <= rd_id;
      best_per_q <= rd_per;
      best_due_q <= rd_due;
    end
  end

endmodule

// ----- design/pes_ctrl.sv -----
// ----------------------------------------------------------------------------
// pes_ctrl: sequencer of the scheduler
// accepts one transaction, runs register, clear or scan, then offers the result
// ----------------------------------------------------------------------------
module pes_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic [pes_pkg::FuncBits-1:0] func_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output pes_pkg::pes_cmd_t            cmd_o,
  input  pes_pkg::pes_stat_t           stat_i
);
  import pes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_FIRE, S_OUT
  } state_e;

  state_e           state_q;
  logic [FuncBits-1:0] func_q;
  logic             out_q;

  assign s_ready_o = (state_q == S_IDLE) || (state_q == S_OUT && m_ready_i);
  assign m_valid_o = out_q;

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.load = s_valid_i && s_ready_o;
    case (state_q)
      S_DECODE: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.reg_write  = (func_q == FUNC_REGISTER) && !stat_i.full;
        cmd_o.clear      = (func_q == FUNC_CLEAR);
      end
      S_SCAN:  cmd_o.scan_step = 1'b1;
      S_FIRE:  cmd_o.fire      = 1'b1;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q  <= FUNC_REGISTER;
      out_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE, S_OUT: begin
          if (cmd_o.load) begin
            out_q   <= 1'b0;
            func_q  <= func_i;
            state_q <= S_DECODE;
          end else if (state_q == S_OUT && m_ready_i) begin
            out_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        S_DECODE: begin
          if (func_q == FUNC_DISPATCH && !stat_i.empty) begin
            state_q <= S_SCAN;
          end else begin
            out_q   <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_SCAN: begin
          if (stat_i.scan_last) state_q <= S_FIRE;
        end
        S_FIRE: begin
          out_q   <= 1'b1;
          state_q <= S_OUT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/periodic_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_event_scheduler: periodic event table with earliest-due dispatch
// register, dispatch and clear transactions, one result transaction each
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command per transaction: tuser holds func, tdata holds
//   entry_id and period. m_axis returns one result per command: tuser holds
//   status, tdata holds dispatched_id and dispatch_time.
// sequence and throughput
//   register, clear, unused codes and a dispatch on an empty table pass
//   through S_DECODE to S_OUT, where the result is offered.
//   a dispatch scans every stored entry through the single read port of the
//   entry memory, one slot per cycle, passing S_DECODE, S_SCAN and S_FIRE
//   before S_OUT. one command is in flight at a time; the next command is
//   accepted in the cycle its predecessor's result is taken.
// reset
//   the table is empty after reset; entry contents need no clearing since
//   only slots below the entry count are ever compared.
// stall
//   the result register holds its value while m_axis_tready is low and no
//   new command is taken until it has been delivered.
// ----------------------------------------------------------------------------
module periodic_event_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned ID_BITS     = 32,
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // entry_id, period
  input  logic [((ID_BITS+PERIOD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [pes_pkg::FuncBits-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // dispatched_id, dispatch_time
  output logic [((ID_BITS+TIME_BITS+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [pes_pkg::StatusBits-1:0] m_axis_tuser
);
  import pes_pkg::*;

  localparam int unsigned OW = ((ID_BITS+TIME_BITS+7)/8)*8;

  pes_cmd_t  cmd;
  pes_stat_t stat;
  logic [ID_BITS-1:0]   res_id;
  logic [TIME_BITS-1:0] res_time;

  // controller
  pes_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .func_i    (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  // datapath
  pes_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .PERIOD_BITS (PERIOD_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .entry_id_i      (s_axis_tdata[ID_BITS-1:0]),
    .period_i        (s_axis_tdata[ID_BITS +: PERIOD_BITS]),
    .func_i          (s_axis_tuser),
    .status_o        (m_axis_tuser),
    .dispatched_id_o (res_id),
    .dispatch_time_o (res_time)
  );

  // result packing
  assign m_axis_tdata = OW'({res_time, res_id});

endmodule
